[src/pdec_pkg.sv]
package pdec_pkg;

	localparam int unsigned GROUP_MAX = 3;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// decoded bytes produced by one accepted input byte
	typedef struct packed {
		logic [1:0]                cnt;
		logic [GROUP_MAX-1:0][7:0] chars;
		logic                      last;
	} pdec_group_t;

endpackage

[src/percent_decoder_unit.sv]
// Channel   Direction  Contents
// s_*       in         tdata[7:0] in_char, tlast end_of_string
// m_*       out        tdata[7:0] out_char, tlast out_final
// cfg_*     in         cfg_wdata plus_to_space, written when cfg_we is high
//
// One input byte is taken per cycle while the group queue has room; the first
// result of a byte passes through the group queue and then the output register.
// A byte that yields two or three results sends them out one by one on the
// output port; the queue of QUEUE_DEPTH groups absorbs those bursts.
// Reset: plus_to_space is 1, no escape pending, queue and output empty.
// Either side may stall on its own; a stalled output holds its data.
module percent_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,   // plus_to_space
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // [7:0] in_char
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,     // [7:0] out_char
	output logic       m_tlast
);
	import pdec_pkg::*;

	pdec_group_t q_wdata, q_head;
	logic        q_push, q_pop, q_empty, q_full;

	pdec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	pdec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	pdec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[src/pdec_front.sv]
module pdec_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 s_tlast,
	input  logic                 q_full,
	output logic                 q_push,
	output pdec_pkg::pdec_group_t q_wdata
);
	import pdec_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	phase_t     phase_q, phase_nx;
	logic [7:0] held_q, held_nx;
	logic       plus_to_space_q;
	logic       accept;
	logic       consumed;
	logic [1:0] n;
	logic [4:0] hx_in, hx_held;
	pdec_group_t grp;

	// bit 4 set marks a hex digit, bits 3:0 give its value
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	assign hx_in    = hex_of(s_tdata);
	assign hx_held  = hex_of(held_q);
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		grp      = '0;
		n        = 2'd0;
		phase_nx = PH_IDLE;
		held_nx  = held_q;
		consumed = 1'b0;
		case (phase_q)
			PH_PCT: begin
				if (hx_in[4]) begin
					held_nx  = s_tdata;
					phase_nx = PH_DIGIT;
					consumed = 1'b1;
				end else begin
					grp.chars[n] = CH_PERCENT;
					n = n + 2'd1;
				end
			end
			PH_DIGIT: begin
				if (hx_in[4]) begin
					grp.chars[n] = {hx_held[3:0], hx_in[3:0]};
					n = n + 2'd1;
					consumed = 1'b1;
				end else begin
					grp.chars[n] = CH_PERCENT;
					n = n + 2'd1;
					grp.chars[n] = held_q;
					n = n + 2'd1;
				end
				held_nx = '0;
			end
			default: ;
		endcase
		if (!consumed) begin
			if (s_tdata == CH_PERCENT) begin
				phase_nx = PH_PCT;
			end else if (s_tdata == CH_PLUS && plus_to_space_q) begin
				grp.chars[n] = CH_SPACE;
				n = n + 2'd1;
			end else begin
				grp.chars[n] = s_tdata;
				n = n + 2'd1;
			end
		end
		// flush whatever escape is still open at the end of the string
		if (s_tlast) begin
			if (phase_nx == PH_PCT) begin
				grp.chars[n] = CH_PERCENT;
				n = n + 2'd1;
			end else if (phase_nx == PH_DIGIT) begin
				grp.chars[n] = CH_PERCENT;
				n = n + 2'd1;
				grp.chars[n] = held_nx;
				n = n + 2'd1;
			end
			phase_nx = PH_IDLE;
			held_nx  = '0;
		end
		grp.cnt  = n;
		grp.last = s_tlast;
	end

	assign q_push  = accept && (n != 2'd0);
	assign q_wdata = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			held_q          <= '0;
			plus_to_space_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				plus_to_space_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= phase_nx;
				held_q  <= held_nx;
			end
		end
	end

	a_last_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (phase_q == PH_IDLE && held_q == 8'd0))
		else $error("escape state left open after end of string");

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |-> q_push)
		else $error("end of string produced no output transaction");

endmodule

[src/pdec_queue.sv]
module pdec_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pdec_pkg::pdec_group_t wdata,
	input  logic                  pop,
	output pdec_pkg::pdec_group_t head,
	output logic                  empty,
	output logic                  full
);
	import pdec_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	pdec_group_t     mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CntW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

[src/pdec_back.sv]
module pdec_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdec_pkg::pdec_group_t head,
	input  logic                  empty,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);
	import pdec_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       last_byte;

	assign load      = !empty && (!m_tvalid || m_tready);
	assign last_byte = (idx_q == head.cnt - 2'd1);
	assign pop       = load && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load) begin
				m_tvalid <= 1'b1;
				idx_q    <= last_byte ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= head.chars[idx_q];
			m_tlast <= head.last && last_byte;
		end
	end

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q < head.cnt))
		else $error("byte index outside its group");

	a_last_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		(load && head.last && last_byte) |=> (m_tlast && idx_q == 2'd0))
		else $error("final byte not marked or group not retired");

endmodule
